[hdl/rc6_variant_block_cipher_macros.svh]
// Assertion macros shared by the cipher block.
`ifndef RC6_VARIANT_BLOCK_CIPHER_MACROS_SVH
`define RC6_VARIANT_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RC6V_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rc6v assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RC6V_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rc6v assertion failed");

`endif

[hdl/rc6v_pkg.sv]
// Package with constants, sequencer states and helper functions of the cipher.
`timescale 1ns / 1ps

package rc6v_pkg;

    localparam int ROUNDS_DEF = 40;
    localparam logic [31:0] P32 = 32'hb7e15163;
    localparam logic [31:0] Q32 = 32'h9e3779b9;
    localparam logic [4:0] MIX_ROT = 5'd5;
    localparam logic [4:0] SCHED_ROT = 5'd3;

    localparam logic [7:0] KEY_TABLE [32] = '{
        8'h76, 8'hb7, 8'h4b, 8'h98, 8'h4c, 8'h5b, 8'hd5, 8'he3,
        8'hc1, 8'h92, 8'h33, 8'h6a, 8'h7b, 8'he6, 8'hcc, 8'heb,
        8'h17, 8'h9a, 8'h77, 8'hbc, 8'h31, 8'h5d, 8'he7, 8'h39,
        8'ha9, 8'h32, 8'h54, 8'h88, 8'h66, 8'hd3, 8'hce, 8'h43
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KINIT,
        ST_KRD,
        ST_KA,
        ST_KB,
        ST_LD0,
        ST_PRE0,
        ST_PRE1,
        ST_RMT,
        ST_RMU,
        ST_RX1,
        ST_RX2,
        ST_POST0,
        ST_POST1,
        ST_DONE
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} >> n;
        return tmp[31:0];
    endfunction

    // Key word w: four table bytes, each plus a sign-extended user key byte,
    // combined little-endian with carries running modulo 2^32.
    function automatic logic [31:0] key_word(input logic [2:0] w, input logic [31:0] uk);
        logic [31:0] acc;
        logic [31:0] tj;
        logic [7:0] ub;
        acc = '0;
        for (int j = 0; j < 4; j++) begin
            ub = uk[8 * (3 - j) +: 8];
            tj = {24'd0, KEY_TABLE[{w, 2'(j)}]} + {{24{ub[7]}}, ub};
            acc = acc + (tj << (8 * j));
        end
        return acc;
    endfunction

endpackage

[hdl/rc6v_mix_unit.sv]
// Shared mixing unit: registered rotl(x * (2x + 1), 5).
`timescale 1ns / 1ps

module rc6v_mix_unit
    import rc6v_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] x,
    output logic [31:0] y
);

    logic [31:0] y_reg;
    logic [31:0] prod;

    assign prod = x * {x[30:0], 1'b1};

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= rotl32(prod, MIX_ROT);
        end
    end

    assign y = y_reg;

endmodule

[hdl/rc6_variant_block_cipher.sv]
// Top level of the iterative RC6-32 variant block cipher.
// The first block after reset or a key write adds the schedule expansion (ST_KINIT,
// ST_KRD, then ST_KA and ST_KB per step) before the rounds begin.
// Blocks are taken one at a time: s_tready is high only in ST_IDLE. Each round steps
// through ST_RMT, ST_RMU, ST_RX1 and ST_RX2.
// Reset clears control state and the key; round keys are rebuilt before first use.
`timescale 1ns / 1ps

module rc6_variant_block_cipher
    import rc6v_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,     // user_key
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,      // in_word0, in_word1, in_word2, in_word3
    input  logic         s_tuser,      // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata       // out_word0, out_word1, out_word2, out_word3
);

`include "rc6_variant_block_cipher_macros.svh"

    localparam int NKEYS = 2 * ROUNDS + 4;
    localparam int MIXN = (NKEYS > 8) ? NKEYS : 8;
    localparam int STEPS = 3 * MIXN;
    localparam int KW = $clog2(NKEYS);
    localparam int CW = $clog2(STEPS);
    localparam int RW = $clog2(ROUNDS + 1);

    localparam logic [KW-1:0] K_ZERO = '0;
    localparam logic [KW-1:0] K_ONE = KW'(1);
    localparam logic [KW-1:0] K_LAST = KW'(NKEYS - 1);
    localparam logic [KW-1:0] K_2R2 = KW'(2 * ROUNDS + 2);
    localparam logic [KW-1:0] K_2R3 = KW'(2 * ROUNDS + 3);
    localparam logic [CW-1:0] CNT_NKEYS = CW'(NKEYS);
    localparam logic [CW-1:0] CNT_INIT_END = CW'(MIXN - 1);
    localparam logic [CW-1:0] CNT_STEP_END = CW'(STEPS - 1);
    localparam logic [CW-1:0] CNT_MIXW = CW'(8);
    localparam logic [RW-1:0] R_ONE = RW'(1);
    localparam logic [RW-1:0] R_LAST = RW'(ROUNDS);

    state_t state_reg, state_next;

    logic [31:0]   a_reg, b_reg, c_reg, d_reg, x_reg, t_reg;
    logic          func_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] cnt_reg;
    logic [KW-1:0] ki_reg;
    logic [2:0]    li_reg;
    logic [31:0]   ka_reg, kb_reg, sval_reg;
    logic [31:0]   lw_reg [8];
    logic [31:0]   uk_reg;
    logic          sched_valid_reg;
    logic [127:0]  m_data_reg;
    logic          m_valid_reg;

    logic [31:0]   rk_mem [NKEYS];
    logic [31:0]   rk_rd_reg;
    logic [KW-1:0] rd_addr;
    logic          wr_en;
    logic [KW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic          mix_en;
    logic [31:0]   mix_x;
    logic [31:0]   mix_y;

    logic [31:0]   ka_new, kab_sum, kb_new;
    logic [KW-1:0] ki_next;
    logic          last_round;
    logic          out_free;

    rc6v_mix_unit u_mix (
        .aclk (aclk),
        .en   (mix_en),
        .x    (mix_x),
        .y    (mix_y)
    );

    assign ka_new = rotl32(rk_rd_reg + ka_reg + kb_reg, SCHED_ROT);
    assign kab_sum = ka_reg + kb_reg;
    assign kb_new = rotl32(lw_reg[li_reg] + kab_sum, kab_sum[4:0]);
    assign ki_next = (ki_reg == K_LAST) ? K_ZERO : ki_reg + K_ONE;
    assign last_round = func_reg ? (r_reg == R_ONE) : (r_reg == R_LAST);
    assign out_free = !m_valid_reg || m_tready;

    assign cfg_ready = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    always_comb begin
        state_next = state_reg;
        rd_addr = K_ZERO;
        wr_en = 1'b0;
        wr_addr = ki_reg;
        wr_data = ka_new;
        mix_en = 1'b0;
        mix_x = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sched_valid_reg ? ST_LD0 : ST_KINIT;
                end
            end
            ST_KINIT: begin
                wr_en = (cnt_reg < CNT_NKEYS);
                wr_addr = KW'(cnt_reg);
                wr_data = sval_reg;
                if (cnt_reg == CNT_INIT_END) begin
                    state_next = ST_KRD;
                end
            end
            ST_KRD: begin
                rd_addr = ki_reg;
                state_next = ST_KA;
            end
            ST_KA: begin
                wr_en = 1'b1;
                state_next = ST_KB;
            end
            ST_KB: begin
                rd_addr = ki_next;
                state_next = (cnt_reg == CNT_STEP_END) ? ST_LD0 : ST_KA;
            end
            ST_LD0: begin
                rd_addr = func_reg ? K_2R2 : K_ZERO;
                state_next = ST_PRE0;
            end
            ST_PRE0: begin
                rd_addr = func_reg ? K_2R3 : K_ONE;
                state_next = ST_PRE1;
            end
            ST_PRE1: begin
                state_next = ST_RMT;
            end
            ST_RMT: begin
                mix_en = 1'b1;
                mix_x = func_reg ? a_reg : b_reg;
                state_next = ST_RMU;
            end
            ST_RMU: begin
                mix_en = 1'b1;
                mix_x = func_reg ? c_reg : d_reg;
                rd_addr = func_reg ? KW'({r_reg, 1'b1}) : KW'({r_reg, 1'b0});
                state_next = ST_RX1;
            end
            ST_RX1: begin
                rd_addr = func_reg ? KW'({r_reg, 1'b0}) : KW'({r_reg, 1'b1});
                state_next = ST_RX2;
            end
            ST_RX2: begin
                if (last_round) begin
                    rd_addr = func_reg ? K_ZERO : K_2R2;
                    state_next = ST_POST0;
                end else begin
                    state_next = ST_RMT;
                end
            end
            ST_POST0: begin
                rd_addr = func_reg ? K_ONE : K_2R3;
                state_next = ST_POST1;
            end
            ST_POST1: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rk_mem[wr_addr] <= wr_data;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    a_reg <= s_tdata[31:0];
                    b_reg <= s_tdata[63:32];
                    c_reg <= s_tdata[95:64];
                    d_reg <= s_tdata[127:96];
                    func_reg <= s_tuser;
                    cnt_reg <= '0;
                    sval_reg <= P32;
                end
            end
            ST_KINIT: begin
                if (cnt_reg < CNT_MIXW) begin
                    lw_reg[cnt_reg[2:0]] <= key_word(cnt_reg[2:0], uk_reg);
                end
                sval_reg <= sval_reg + Q32;
                if (cnt_reg == CNT_INIT_END) begin
                    cnt_reg <= '0;
                    ka_reg <= '0;
                    kb_reg <= '0;
                    ki_reg <= K_ZERO;
                    li_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            ST_KRD: begin
            end
            ST_KA: begin
                ka_reg <= ka_new;
            end
            ST_KB: begin
                lw_reg[li_reg] <= kb_new;
                kb_reg <= kb_new;
                ki_reg <= ki_next;
                li_reg <= li_reg + 3'd1;
                cnt_reg <= cnt_reg + CW'(1);
            end
            ST_LD0: begin
            end
            ST_PRE0: begin
                if (func_reg) begin
                    a_reg <= (a_reg ^ uk_reg) - rk_rd_reg;
                    b_reg <= b_reg ^ uk_reg;
                    d_reg <= d_reg ^ uk_reg;
                end else begin
                    b_reg <= b_reg + rk_rd_reg;
                end
            end
            ST_PRE1: begin
                if (func_reg) begin
                    c_reg <= (c_reg ^ uk_reg) - rk_rd_reg;
                    r_reg <= R_LAST;
                end else begin
                    d_reg <= d_reg + rk_rd_reg;
                    r_reg <= R_ONE;
                end
            end
            ST_RMT: begin
            end
            ST_RMU: begin
                t_reg <= mix_y;
            end
            ST_RX1: begin
                if (func_reg) begin
                    x_reg <= rotr32(b_reg - rk_rd_reg, t_reg[4:0]) ^ mix_y;
                end else begin
                    a_reg <= rotl32(a_reg ^ t_reg, mix_y[4:0]) + rk_rd_reg;
                end
            end
            ST_RX2: begin
                if (func_reg) begin
                    a_reg <= rotr32(d_reg - rk_rd_reg, mix_y[4:0]) ^ t_reg;
                    b_reg <= a_reg;
                    c_reg <= x_reg;
                    d_reg <= c_reg;
                    r_reg <= r_reg - R_ONE;
                end else begin
                    a_reg <= b_reg;
                    b_reg <= rotl32(c_reg ^ mix_y, t_reg[4:0]) + rk_rd_reg;
                    c_reg <= d_reg;
                    d_reg <= a_reg;
                    r_reg <= r_reg + R_ONE;
                end
            end
            ST_POST0: begin
                if (func_reg) begin
                    b_reg <= b_reg - rk_rd_reg;
                end else begin
                    a_reg <= (a_reg + rk_rd_reg) ^ uk_reg;
                    b_reg <= b_reg ^ uk_reg;
                end
            end
            ST_POST1: begin
                if (func_reg) begin
                    d_reg <= d_reg - rk_rd_reg;
                end else begin
                    c_reg <= (c_reg + rk_rd_reg) ^ uk_reg;
                    d_reg <= d_reg ^ uk_reg;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg <= {d_reg, c_reg, b_reg, a_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sched_valid_reg <= 1'b0;
            uk_reg <= '0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_KB && cnt_reg == CNT_STEP_END) begin
                sched_valid_reg <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                uk_reg <= cfg_data;
                sched_valid_reg <= 1'b0;
            end
        end
    end

    `RC6V_ASSERT_IMPL(a_sched_from_expansion, aclk, aresetn,
        $rose(sched_valid_reg), $past(state_reg == ST_KB))
    `RC6V_ASSERT_NEXT(a_key_write_stales, aclk, aresetn,
        cfg_valid && cfg_ready, !sched_valid_reg)
    `RC6V_ASSERT_NEXT(a_accept_starts_work, aclk, aresetn,
        s_tvalid && s_tready, state_reg != ST_IDLE)

endmodule

[tb/sv/rc6_variant_block_cipher_tb.sv]
// Self-checking testbench for the RC6-32 variant block cipher with a scoreboard class.
`timescale 1ns / 1ps

typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
} cipher_op_t;

class cipher_scoreboard;
    localparam int NROUNDS = rc6v_pkg::ROUNDS_DEF;
    localparam int NKEYS = 2 * NROUNDS + 4;
    localparam int NMIX = 8;
    localparam int NSTEPS = 3 * ((NKEYS > NMIX) ? NKEYS : NMIX);

    logic [31:0]  user_key;
    logic [31:0]  rkey [NKEYS];
    logic [31:0]  mix_word [NMIX];
    bit           sched_ok;
    logic [127:0] expected_blocks [$];
    int           mismatches;
    int           unexpected;

    function new();
        user_key = '0;
        sched_ok = 1'b0;
        mismatches = 0;
        unexpected = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, logic [4:0] n);
        return (n == 5'd0) ? x : ((x << n) | (x >> (6'd32 - n)));
    endfunction

    function logic [31:0] ror(logic [31:0] x, logic [4:0] n);
        return (n == 5'd0) ? x : ((x >> n) | (x << (6'd32 - n)));
    endfunction

    function logic [31:0] quad(logic [31:0] x);
        logic [31:0] p;
        p = x * ((x << 1) + 32'd1);
        return rol(p, rc6v_pkg::MIX_ROT);
    endfunction

    function void set_key(logic [31:0] k);
        user_key = k;
        sched_ok = 1'b0;
    endfunction

    function void expand();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] s;
        logic [31:0] ub;
        logic [31:0] sb;
        int          ki;
        int          li;
        for (int w = 0; w < NMIX; w++) mix_word[w] = '0;
        for (int t = 31; t >= 0; t--) begin
            ub = (user_key >> (8 * ((31 - t) % 4))) & 32'hff;
            sb = ub[7] ? (ub | 32'hffffff00) : ub;
            mix_word[t / 4] = (mix_word[t / 4] << 8) + {24'd0, rc6v_pkg::KEY_TABLE[t]} + sb;
        end
        rkey[0] = rc6v_pkg::P32;
        for (int n = 1; n < NKEYS; n++) rkey[n] = rkey[n - 1] + rc6v_pkg::Q32;
        a = '0;
        b = '0;
        ki = 0;
        li = 0;
        for (int n = 0; n < NSTEPS; n++) begin
            a = rol(rkey[ki] + a + b, rc6v_pkg::SCHED_ROT);
            rkey[ki] = a;
            s = a + b;
            b = rol(mix_word[li] + s, s[4:0]);
            mix_word[li] = b;
            ki = (ki + 1) % NKEYS;
            li = (li + 1) % NMIX;
        end
        sched_ok = 1'b1;
    endfunction

    function logic [127:0] predict(cipher_op_t op, logic [127:0] blk);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] t;
        logic [31:0] u;
        logic [31:0] x;
        if (!sched_ok) expand();
        a = blk[31:0];
        b = blk[63:32];
        c = blk[95:64];
        d = blk[127:96];
        if (op == OP_ENCRYPT) begin
            b = b + rkey[0];
            d = d + rkey[1];
            for (int r = 1; r <= NROUNDS; r++) begin
                t = quad(b);
                u = quad(d);
                a = rol(a ^ t, u[4:0]) + rkey[2 * r];
                c = rol(c ^ u, t[4:0]) + rkey[2 * r + 1];
                x = a;
                a = b;
                b = c;
                c = d;
                d = x;
            end
            a = (a + rkey[NKEYS - 2]) ^ user_key;
            b = b ^ user_key;
            c = (c + rkey[NKEYS - 1]) ^ user_key;
            d = d ^ user_key;
        end else begin
            a = (a ^ user_key) - rkey[NKEYS - 2];
            b = b ^ user_key;
            c = (c ^ user_key) - rkey[NKEYS - 1];
            d = d ^ user_key;
            for (int r = NROUNDS; r >= 1; r--) begin
                x = d;
                d = c;
                c = b;
                b = a;
                a = x;
                u = quad(d);
                t = quad(b);
                c = ror(c - rkey[2 * r + 1], t[4:0]) ^ u;
                a = ror(a - rkey[2 * r], u[4:0]) ^ t;
            end
            b = b - rkey[0];
            d = d - rkey[1];
        end
        return {d, c, b, a};
    endfunction

    function void note_block(cipher_op_t op, logic [127:0] blk);
        expected_blocks.push_back(predict(op, blk));
    endfunction

    function void check_block(logic [127:0] actual);
        logic [127:0] want;
        bit           bad;
        if (expected_blocks.size() == 0) begin
            unexpected++;
            $display("result beat with no block pending: %032h", actual);
            return;
        end
        want = expected_blocks.pop_front();
        bad = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (want[32 * i +: 32] !== actual[32 * i +: 32]) begin
                if (mismatches < 10) begin
                    $display("mismatch out_word%0d: expected %08h, actual %08h",
                             i, want[32 * i +: 32], actual[32 * i +: 32]);
                end
                bad = 1'b1;
            end
        end
        if (bad) mismatches++;
    endfunction

    function int pending();
        return expected_blocks.size();
    endfunction

    function int failures();
        return mismatches + unexpected + expected_blocks.size();
    endfunction
endclass

module rc6_variant_block_cipher_tb;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES = 8;
    localparam int BLOCKS_PER_PHASE = 125;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;    // in_word0, in_word1, in_word2, in_word3
    logic         s_tuser = 1'b0;  // func
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;         // out_word0, out_word1, out_word2, out_word3

    cipher_scoreboard sb = new();
    bit               calm = 1'b0;
    int               sink_hold = 0;
    int               cycles = 0;

    rc6_variant_block_cipher u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0, 1: return 32'h00000000;
            2, 3: return 32'hffffffff;
            4: return 32'h80000000;
            5: return 32'h7fffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_block(input cipher_op_t op, input logic [127:0] blk);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= blk;
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_block(op, blk);
    endtask

    task automatic write_key(input logic [31:0] k);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= k;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_key(k);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_block(m_tdata);
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            sink_hold = gap_len();
            m_tready <= (sink_hold == 0);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cipher_op_t   op;
        cipher_op_t   prev_op;
        logic [127:0] blk;
        logic [127:0] prev_blk;
        logic [31:0]  key;
        bit           have_prev;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The reset key of zero is used before any write.
        send_block(OP_ENCRYPT, '0);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, '0);
        send_block(OP_DECRYPT, '1);
        send_block(OP_ENCRYPT, {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
        send_block(OP_DECRYPT, {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
        send_block(OP_ENCRYPT, {96'd0, 32'd1});
        send_block(OP_DECRYPT, sb.predict(OP_ENCRYPT, '0));

        // Key bytes with the sign bit set and clear exercise the signed byte add.
        write_key(32'hffffffff);
        send_block(OP_ENCRYPT, '0);
        send_block(OP_DECRYPT, '1);
        send_block(OP_DECRYPT, sb.predict(OP_ENCRYPT, '1));
        write_key(32'h80808080);
        send_block(OP_ENCRYPT, '0);
        send_block(OP_DECRYPT, '0);
        send_block(OP_ENCRYPT, '1);
        write_key(32'h7f7f7f7f);
        send_block(OP_ENCRYPT, '0);
        send_block(OP_DECRYPT, '1);
        write_key(32'h00ff807f);
        send_block(OP_ENCRYPT, 128'h0123456789abcdeffedcba9876543210);
        send_block(OP_DECRYPT, sb.predict(OP_ENCRYPT, 128'h0123456789abcdeffedcba9876543210));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: key = 32'h00000000;
                2: key = 32'hffffffff;
                4: key = 32'h80ff7f00;
                default: key = $urandom;
            endcase
            write_key(key);
            calm = (p == 3);
            have_prev = 1'b0;
            for (int i = 0; i < BLOCKS_PER_PHASE; i++) begin
                if (have_prev && $urandom_range(0, 9) < 3) begin
                    // Feed back the previous result through the inverse operation.
                    op = (prev_op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
                    blk = sb.predict(prev_op, prev_blk);
                end else begin
                    op = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
                    blk = {rand_word(), rand_word(), rand_word(), rand_word()};
                end
                send_block(op, blk);
                prev_op = op;
                prev_blk = blk;
                have_prev = 1'b1;
            end
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.failures() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
